// ----- rtl/group_mean_largest_gap_split_top_defines.svh -----
// Assertion helpers for the top-level RTL.
`ifndef GROUP_MEAN_LARGEST_GAP_SPLIT_TOP_DEFINES_SVH
`define GROUP_MEAN_LARGEST_GAP_SPLIT_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define GMLG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define GMLG_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/gmlg_pkg.sv -----
package gmlg_pkg;

    localparam int MAX_GROUPS = 16;
    localparam int COUNT_BITS = 20;
    localparam int VAL_W      = 32;
    localparam int SUM_W      = VAL_W + COUNT_BITS;
    localparam int CNT_W      = COUNT_BITS + 1;
    localparam int GID_W      = 4;
    localparam int N_W        = $clog2(MAX_GROUPS + 1);
    localparam int STEP_W     = $clog2(SUM_W);

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_FEW     = 2'd1;
    localparam logic [1:0] STATUS_NOSPLIT = 2'd2;

    localparam logic FUNC_LOAD     = 1'b0;
    localparam logic FUNC_CLASSIFY = 1'b1;

    typedef struct packed {
        logic                    func;
        logic signed [VAL_W-1:0] sample_value;
        logic [GID_W-1:0]        group_label;
        logic                    last_sample;
    } in_item_t;

    typedef struct packed {
        logic [GID_W-1:0] group_id;
        logic             side;
        logic [1:0]       status;
        logic             last_result;
    } out_item_t;

    // Contents of one group cell; the whole record moves on rotation.
    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [CNT_W-1:0]        count;
        logic signed [VAL_W-1:0] mean;
        logic                    side;
    } grp_t;

    typedef struct packed {
        logic clear;
        logic add;
        logic rotate;
        logic mean_we;
        logic side_we;
    } grp_ctl_t;

    typedef struct packed {
        logic clear;
        logic insert;
        logic shift;
    } sort_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_DWAIT,
        ST_ROT,
        ST_CHECK,
        ST_SCAN,
        ST_SIDE,
        ST_EMIT
    } state_t;

endpackage

// ----- rtl/group_mean_largest_gap_split_top.sv -----
// Group mean largest-gap split.
// Input channel s_valid/s_ready/s_item: load items (func 0) add a Q16.16
// sample to its group; classify items (func 1) ask for a group's side.
// Result channel m_valid/m_ready/m_item: one registered result item.
// Loads without last_sample give no result. A load with last_sample runs
// the batch. Each present group goes through a start state, 52 serial
// divider steps (one bit a cycle), a done state and a rotation; an absent
// group gets only the start state and rotation. Then a check (under three
// groups: one status-few result), the gap scan, a side state and an emit
// pass with one result per present group, each held while the receiver stalls.
// A classify result shows up the cycle after the item is taken.
// One item is in flight at a time: s_ready is high only while idle and the
// result register is empty, so a stalled receiver holds off new items.
// Reset clears all group sums, counts, sides and the split; no sweep.
// The first load after a finished batch starts a fresh batch.
module group_mean_largest_gap_split_top
    import gmlg_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

`include "group_mean_largest_gap_split_top_defines.svh"

    state_t state_reg, state_next;

    logic [GID_W-1:0]        g_reg, g_next;
    logic [N_W-1:0]          n_reg, n_next;
    logic [N_W-1:0]          k_reg, k_next;
    logic [N_W-1:0]          scan_reg, scan_next;
    logic signed [VAL_W-1:0] prev_reg, prev_next;
    logic signed [VAL_W:0]   best_reg, best_next;
    logic signed [VAL_W-1:0] edge_reg, edge_next;
    logic                    split_valid_reg, split_valid_next;
    logic                    batch_closed_reg, batch_closed_next;
    logic                    m_valid_reg, m_valid_next;
    out_item_t               m_item_reg, m_item_next;

    logic                    accept;
    logic                    load_acc;
    logic                    out_free;
    logic signed [VAL_W:0]   gap;

    // group ring: cell 0 is the head, cell i takes cell i+1 on rotation
    grp_t     grp      [MAX_GROUPS];
    grp_ctl_t grp_ctl  [MAX_GROUPS];
    logic     ring_rot;
    logic     ring_mean_we;
    logic     ring_side_we;

    // sorted chain of means, ascending from cell 0
    logic                    srt_keep  [MAX_GROUPS];
    logic                    srt_valid [MAX_GROUPS];
    logic signed [VAL_W-1:0] srt_val   [MAX_GROUPS];
    sort_ctl_t               srt_ctl;

    logic                    div_start;
    logic                    div_busy;
    logic                    div_done;
    logic signed [VAL_W-1:0] div_q;

    assign s_ready  = (state_reg == ST_IDLE) && !m_valid_reg;
    assign accept   = s_valid && s_ready;
    assign load_acc = accept && (s_item.func == FUNC_LOAD);
    assign out_free = !m_valid_reg || m_ready;
    assign gap      = (VAL_W+1)'(srt_val[0]) - (VAL_W+1)'(prev_reg);

    for (genvar i = 0; i < MAX_GROUPS; i++) begin : g_grp
        always_comb begin
            grp_ctl[i].clear   = load_acc && batch_closed_reg;
            grp_ctl[i].add     = load_acc && (s_item.group_label == GID_W'(i));
            grp_ctl[i].rotate  = ring_rot;
            grp_ctl[i].mean_we = ring_mean_we && (i == 0);
            grp_ctl[i].side_we = ring_side_we;
        end

        gmlg_group_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl      (grp_ctl[i]),
            .sample   (s_item.sample_value),
            .mean_in  (div_q),
            .edge_val (edge_reg),
            .nbr      (grp[(i + 1) % MAX_GROUPS]),
            .cur      (grp[i])
        );

        gmlg_sort_cell u_sort (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctl        (srt_ctl),
            .ins_val    (div_q),
            .prev_keep  ((i == 0) ? 1'b1 : srt_keep[(i + MAX_GROUPS - 1) % MAX_GROUPS]),
            .prev_valid ((i == 0) ? 1'b0 : srt_valid[(i + MAX_GROUPS - 1) % MAX_GROUPS]),
            .prev_val   (srt_val[(i + MAX_GROUPS - 1) % MAX_GROUPS]),
            .next_valid ((i == MAX_GROUPS - 1) ? 1'b0 : srt_valid[(i + 1) % MAX_GROUPS]),
            .next_val   (srt_val[(i + 1) % MAX_GROUPS]),
            .keep       (srt_keep[i]),
            .valid      (srt_valid[i]),
            .val        (srt_val[i])
        );
    end

    gmlg_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (grp[0].sum),
        .divisor  (grp[0].count),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (load_acc && s_item.last_sample) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                state_next = (grp[0].count != '0) ? ST_DWAIT : ST_ROT;
            end
            ST_DWAIT: begin
                if (div_done) begin
                    state_next = ST_ROT;
                end
            end
            ST_ROT: begin
                state_next = (g_reg == GID_W'(MAX_GROUPS - 1)) ? ST_CHECK : ST_DIV;
            end
            ST_CHECK: begin
                state_next = (n_reg < N_W'(3)) ? ST_IDLE : ST_SCAN;
            end
            ST_SCAN: begin
                if (scan_reg == n_reg - N_W'(1)) begin
                    state_next = ST_SIDE;
                end
            end
            ST_SIDE: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free && g_reg == GID_W'(MAX_GROUPS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        g_next            = g_reg;
        n_next            = n_reg;
        k_next            = k_reg;
        scan_next         = scan_reg;
        prev_next         = prev_reg;
        best_next         = best_reg;
        edge_next         = edge_reg;
        split_valid_next  = split_valid_reg;
        batch_closed_next = batch_closed_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_item_next       = m_item_reg;
        ring_rot          = 1'b0;
        ring_mean_we      = 1'b0;
        ring_side_we      = 1'b0;
        srt_ctl           = '0;
        div_start         = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (load_acc) begin
                    if (batch_closed_reg) begin
                        split_valid_next = 1'b0;
                    end
                    batch_closed_next = s_item.last_sample;
                    g_next            = '0;
                    n_next            = '0;
                    srt_ctl.clear     = 1'b1;
                end else if (accept) begin
                    m_valid_next         = 1'b1;
                    m_item_next.group_id = s_item.group_label;
                    m_item_next.last_result = 1'b1;
                    if (split_valid_reg && grp[s_item.group_label].count != '0) begin
                        m_item_next.side   = grp[s_item.group_label].side;
                        m_item_next.status = STATUS_OK;
                    end else begin
                        m_item_next.side   = 1'b0;
                        m_item_next.status = STATUS_NOSPLIT;
                    end
                end
            end
            ST_DIV: begin
                div_start = (grp[0].count != '0);
            end
            ST_DWAIT: begin
                if (div_done) begin
                    ring_mean_we   = 1'b1;
                    srt_ctl.insert = 1'b1;
                    n_next         = n_reg + N_W'(1);
                end
            end
            ST_ROT: begin
                ring_rot = 1'b1;
                g_next   = g_reg + GID_W'(1);
            end
            ST_CHECK: begin
                if (n_reg < N_W'(3)) begin
                    split_valid_next = 1'b0;
                    m_valid_next     = 1'b1;
                    m_item_next      = '{group_id: '0, side: 1'b0,
                                         status: STATUS_FEW, last_result: 1'b1};
                end else begin
                    prev_next     = srt_val[0];
                    srt_ctl.shift = 1'b1;
                    scan_next     = N_W'(1);
                end
            end
            ST_SCAN: begin
                if (scan_reg == N_W'(1) || gap > best_reg) begin
                    best_next = gap;
                    edge_next = prev_reg;
                end
                prev_next     = srt_val[0];
                srt_ctl.shift = 1'b1;
                scan_next     = scan_reg + N_W'(1);
            end
            ST_SIDE: begin
                ring_side_we     = 1'b1;
                split_valid_next = 1'b1;
                g_next           = '0;
                k_next           = '0;
            end
            ST_EMIT: begin
                if (out_free) begin
                    ring_rot = 1'b1;
                    g_next   = g_reg + GID_W'(1);
                    if (grp[0].count != '0) begin
                        m_valid_next = 1'b1;
                        m_item_next  = '{group_id: g_reg, side: grp[0].side,
                                         status: STATUS_OK,
                                         last_result: (k_reg == n_reg - N_W'(1))};
                        k_next       = k_reg + N_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            split_valid_reg  <= 1'b0;
            batch_closed_reg <= 1'b0;
            m_valid_reg      <= 1'b0;
            g_reg            <= '0;
            n_reg            <= '0;
            k_reg            <= '0;
            scan_reg         <= '0;
        end else begin
            state_reg        <= state_next;
            split_valid_reg  <= split_valid_next;
            batch_closed_reg <= batch_closed_next;
            m_valid_reg      <= m_valid_next;
            g_reg            <= g_next;
            n_reg            <= n_next;
            k_reg            <= k_next;
            scan_reg         <= scan_next;
        end
        prev_reg   <= prev_next;
        best_reg   <= best_next;
        edge_reg   <= edge_next;
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    `GMLG_ASSERT_NOW(a_ready_out_empty, s_ready, !m_valid_reg, "input taken with result pending")
    `GMLG_ASSERT_NOW(a_div_idle_start, div_start, !div_busy, "divider restarted while busy")
    `GMLG_ASSERT_NXT(a_few_result, (state_reg == ST_CHECK) && (n_reg < N_W'(3)),
                     m_valid_reg && (m_item_reg.status == STATUS_FEW), "missing few-groups result")
    `GMLG_ASSERT_NOW(a_n_range, state_reg == ST_SCAN, n_reg >= N_W'(3), "scan with too few groups")

endmodule

// ----- rtl/gmlg_group_cell.sv -----
module gmlg_group_cell
    import gmlg_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  grp_ctl_t                ctl,
    input  logic signed [VAL_W-1:0] sample,
    input  logic signed [VAL_W-1:0] mean_in,
    input  logic signed [VAL_W-1:0] edge_val,
    input  grp_t                    nbr,
    output grp_t                    cur
);

    grp_t cur_reg, cur_next;

    always_comb begin
        cur_next = cur_reg;
        if (ctl.clear) begin
            cur_next.sum   = ctl.add ? SUM_W'(sample) : '0;
            cur_next.count = ctl.add ? CNT_W'(1) : '0;
            cur_next.side  = 1'b0;
        end else if (ctl.add && !cur_reg.count[COUNT_BITS]) begin
            cur_next.sum   = cur_reg.sum + SUM_W'(sample);
            cur_next.count = cur_reg.count + CNT_W'(1);
        end else if (ctl.rotate) begin
            cur_next = nbr;
        end else if (ctl.mean_we) begin
            cur_next.mean = mean_in;
        end else if (ctl.side_we) begin
            cur_next.side = (cur_reg.mean <= edge_val) ? 1'b0 : 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg <= '0;
        end else begin
            cur_reg <= cur_next;
        end
    end

    assign cur = cur_reg;

endmodule

// ----- rtl/gmlg_sort_cell.sv -----
module gmlg_sort_cell
    import gmlg_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  sort_ctl_t               ctl,
    input  logic signed [VAL_W-1:0] ins_val,
    input  logic                    prev_keep,
    input  logic                    prev_valid,
    input  logic signed [VAL_W-1:0] prev_val,
    input  logic                    next_valid,
    input  logic signed [VAL_W-1:0] next_val,
    output logic                    keep,
    output logic                    valid,
    output logic signed [VAL_W-1:0] val
);

    logic                    valid_reg, valid_next;
    logic signed [VAL_W-1:0] val_reg, val_next;

    // empty cells act as +infinity
    assign keep = valid_reg && (val_reg <= ins_val);

    always_comb begin
        valid_next = valid_reg;
        val_next   = val_reg;
        if (ctl.clear) begin
            valid_next = 1'b0;
        end else if (ctl.insert && !keep) begin
            valid_next = 1'b1;
            if (prev_keep) begin
                val_next = ins_val;
            end else begin
                val_next   = prev_val;
                valid_next = prev_valid;
            end
        end else if (ctl.shift) begin
            valid_next = next_valid;
            val_next   = next_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        val_reg <= val_next;
    end

    assign valid = valid_reg;
    assign val   = val_reg;

endmodule

// ----- rtl/gmlg_divider.sv -----
module gmlg_divider
    import gmlg_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic signed [SUM_W-1:0] dividend,
    input  logic [CNT_W-1:0]        divisor,
    output logic                    busy,
    output logic                    done,
    output logic signed [VAL_W-1:0] quotient
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [SUM_W-1:0]  dvd_reg, dvd_next;
    logic [CNT_W:0]    rem_reg, rem_next;
    logic [CNT_W-1:0]  dvs_reg, dvs_next;
    logic              neg_reg, neg_next;
    logic [CNT_W:0]    rem_shift;
    logic              ge;
    logic [SUM_W-1:0]  q_signed;

    // restoring, one quotient bit per cycle; quotient shifts into dvd_reg
    assign rem_shift = {rem_reg[CNT_W-1:0], dvd_reg[SUM_W-1]};
    assign ge        = rem_shift >= {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            dvs_next  = divisor;
            neg_next  = dividend[SUM_W-1];
            dvd_next  = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
        end else if (busy_reg) begin
            rem_next  = ge ? (rem_shift - {1'b0, dvs_reg}) : rem_shift;
            dvd_next  = {dvd_reg[SUM_W-2:0], ge};
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(SUM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        step_reg <= step_next;
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        neg_reg  <= neg_next;
    end

    assign q_signed = neg_reg ? (-dvd_reg) : dvd_reg;
    assign quotient = q_signed[VAL_W-1:0];
    assign busy     = busy_reg;
    assign done     = done_reg;

endmodule

// ----- sim/tb_group_mean_largest_gap_split_top.sv -----
`timescale 1ns / 100ps

module tb_group_mean_largest_gap_split_top;
    import gmlg_pkg::*;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_item;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_item;

    group_mean_largest_gap_split_top uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    // 8 ns clock
    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    // Predictor state: mirrors the block's group accumulators and split.
    logic signed [SUM_W-1:0] pred_sum   [MAX_GROUPS];
    logic [CNT_W-1:0]        pred_count [MAX_GROUPS];
    logic                    pred_side  [MAX_GROUPS];
    logic                    pred_split_ok;
    logic                    pred_batch_done;

    out_item_t expected_results[$];
    int        mismatch_count;
    int        send_idle_pct;
    int        recv_idle_pct;

    // Queue up one result item.
    function automatic void push_result(logic [3:0] gid, logic sd, logic [1:0] st,
                                        logic lst);
        out_item_t r;
        r.group_id    = gid;
        r.side        = sd;
        r.status      = st;
        r.last_result = lst;
        expected_results.push_back(r);
    endfunction

    // Close: means, largest gap, sides, one result per present group, or status few.
    function automatic void split_batch();
        int          ids [MAX_GROUPS];
        longint      means [MAX_GROUPS];
        int          n;
        int          best;
        int          j;
        int          k;
        longint      m;
        int          id;
        longint      best_gap;
        longint      gap;
        longint      edge_mean;
        n = 0;
        for (int g = 0; g < MAX_GROUPS; g++) begin
            if (pred_count[g] != 0) begin
                ids[n] = g;
                // SV signed division truncates toward zero, same as the block
                means[n] = longint'(pred_sum[g]) / longint'({1'b0, pred_count[g]});
                n++;
            end
        end
        if (n < 3) begin
            pred_split_ok = 1'b0;
            push_result(4'd0, 1'b0, STATUS_FEW, 1'b1);
            return;
        end
        // stable insertion sort keeps the first of equal means in id order
        for (int i = 1; i < n; i++) begin
            m = means[i];
            id = ids[i];
            j = i - 1;
            while (j >= 0 && means[j] > m) begin
                means[j + 1] = means[j];
                ids[j + 1] = ids[j];
                j--;
            end
            means[j + 1] = m;
            ids[j + 1] = id;
        end
        best = 0;
        best_gap = means[1] - means[0];
        for (int i = 1; i < n - 1; i++) begin
            gap = means[i + 1] - means[i];
            if (gap > best_gap) begin
                best_gap = gap;
                best = i;
            end
        end
        edge_mean = means[best];
        for (int i = 0; i < n; i++)
            pred_side[ids[i]] = (means[i] <= edge_mean) ? 1'b0 : 1'b1;
        pred_split_ok = 1'b1;
        k = 0;
        for (int g = 0; g < MAX_GROUPS; g++) begin
            if (pred_count[g] != 0) begin
                push_result(g[3:0], pred_side[g], STATUS_OK, (k == n - 1));
                k++;
            end
        end
    endfunction

    function automatic void predict_item(in_item_t it);
        if (it.func == FUNC_LOAD) begin
            if (pred_batch_done) begin
                for (int g = 0; g < MAX_GROUPS; g++) begin
                    pred_sum[g] = '0;
                    pred_count[g] = '0;
                    pred_side[g] = 1'b0;
                end
                pred_split_ok = 1'b0;
                pred_batch_done = 1'b0;
            end
            // a full group count drops further samples
            if (pred_count[it.group_label] < (1 << COUNT_BITS)) begin
                pred_sum[it.group_label] = pred_sum[it.group_label] + it.sample_value;
                pred_count[it.group_label] = pred_count[it.group_label] + 1'b1;
            end
            if (it.last_sample) begin
                pred_batch_done = 1'b1;
                split_batch();
            end
        end else if (!pred_split_ok || pred_count[it.group_label] == 0) begin
            push_result(it.group_label, 1'b0, STATUS_NOSPLIT, 1'b1);
        end else begin
            push_result(it.group_label, pred_side[it.group_label], STATUS_OK, 1'b1);
        end
    endfunction

    // Send one item; predict on acceptance. Valid drops only for idle gaps.
    task automatic send_item(logic fn, logic signed [31:0] val, logic [3:0] lbl,
                             logic lst);
        in_item_t it;
        it.func = fn;
        it.sample_value = val;
        it.group_label = lbl;
        it.last_sample = lst;
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do
                @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        predict_item(it);
    endtask

    task automatic send_load(logic signed [31:0] val, logic [3:0] lbl, logic lst);
        send_item(FUNC_LOAD, val, lbl, lst);
    endtask

    task automatic send_classify(logic [3:0] lbl);
        send_item(FUNC_CLASSIFY, $urandom, lbl, 1'($urandom_range(1)));
    endtask

    // Result side: random stalls, compare each item against the oldest expectation.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result item: %p", m_item);
                end else begin
                    out_item_t e;
                    e = expected_results.pop_front();
                    if (m_item.group_id !== e.group_id || m_item.side !== e.side ||
                        m_item.status !== e.status ||
                        m_item.last_result !== e.last_result) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("result mismatch: expected %p, got %p", e, m_item);
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0)
            @(posedge aclk);
    endtask

    // Empty state: classify must answer no split.
    task automatic test_classify_before_batch();
        send_classify(4'd0);
        send_classify(4'd15);
    endtask

    // Batches with fewer than three groups report status few.
    task automatic test_few_groups();
        send_load(32'sh7fffffff, 4'd3, 1'b1);
        send_classify(4'd3);
        send_load(-32'sh80000000, 4'd0, 1'b0);
        send_load(32'sh00010000, 4'd15, 1'b1);
    endtask

    // Extremes of the sample, all-equal means and truncation of negative means.
    task automatic test_extremes();
        send_load(32'sh80000000, 4'd0, 1'b0);
        send_load(32'sh80000000, 4'd0, 1'b0);
        send_load(32'sh7fffffff, 4'd15, 1'b0);
        send_load(32'sh7fffffff, 4'd15, 1'b0);
        send_load(32'sh00000000, 4'd7, 1'b1);
        send_classify(4'd0);
        send_classify(4'd15);
        send_classify(4'd8);
        // all means equal: every group lands on side 0
        send_load(32'sh00020000, 4'd1, 1'b0);
        send_load(32'sh00020000, 4'd2, 1'b0);
        send_load(32'sh00020000, 4'd9, 1'b1);
        send_classify(4'd2);
        // truncation of negative means toward zero
        send_load(-32'sd3, 4'd4, 1'b0);
        send_load(-32'sd2, 4'd4, 1'b0);
        send_load(32'sd5, 4'd5, 1'b0);
        send_load(32'sd2, 4'd5, 1'b0);
        send_load(-32'sd1, 4'd6, 1'b1);
        send_classify(4'd6);
    endtask

    // Random batches of up to 16 groups, each closed by a last sample, plus classifies.
    task automatic test_random_batches(int n_items);
        int sent;
        int groups;
        int len;
        logic [3:0] lbl;
        logic signed [31:0] v;
        sent = 0;
        while (sent < n_items) begin
            groups = $urandom_range(16, 1);
            len = $urandom_range(20, 1);
            for (int i = 0; i < len; i++) begin
                lbl = 4'($urandom_range(groups - 1));
                case ($urandom_range(3))
                    0: v = $urandom;
                    1: v = $signed($urandom_range(4000)) - 2000;
                    default: v = 32'(int'($urandom_range(255)) * int'(lbl) * 65536);
                endcase
                send_load(v, lbl, i == len - 1);
                sent++;
            end
            for (int i = $urandom_range(3); i > 0; i--) begin
                send_classify(4'($urandom));
                sent++;
            end
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_item = '0;
        mismatch_count = 0;
        pred_split_ok = 1'b0;
        pred_batch_done = 1'b0;
        for (int g = 0; g < MAX_GROUPS; g++) begin
            pred_sum[g] = '0;
            pred_count[g] = '0;
            pred_side[g] = 1'b0;
        end
        send_idle_pct = 35;
        recv_idle_pct = 79;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_classify_before_batch();
        test_few_groups();
        test_extremes();
        // hold off until everything is out
        wait_drained();
        test_random_batches(130);

        send_idle_pct = 79;
        recv_idle_pct = 35;
        test_random_batches(130);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_batches(140);

        wait_drained();
        repeat (1000) @(posedge aclk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // The timeout below leaves ample headroom for the batches.
    initial begin
        #40ms;
        $display("simulation failed");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/gmlg_pkg.sv
rtl/gmlg_group_cell.sv
rtl/gmlg_sort_cell.sv
rtl/gmlg_divider.sv
rtl/group_mean_largest_gap_split_top.sv
sim/tb_group_mean_largest_gap_split_top.sv
